/* design/ubds_pkg.sv */
package ubds_pkg;

   localparam int unsigned BaudWidth  = 21;
   localparam int unsigned PclkWidth  = 31;
   localparam int unsigned DvdWidth   = 48;
   localparam int unsigned DvsWidth   = 32;
   localparam int unsigned ActWidth   = 29;
   localparam int unsigned MagWidth   = 46;
   localparam int unsigned QueueDepth = 4;

   localparam logic [6:0]  PctScale    = 7'd100;
   localparam logic [6:0]  RoundHalf   = 7'd50;
   localparam logic [16:0] ErrScale    = 17'd100000;
   // rounded quotient at which the register value reaches 256
   localparam logic [14:0] RateLimit   = 15'd25700;
   // ceil(2^19 / 100), exact for the rounded quotients below RateLimit
   localparam logic [12:0] PctRecip    = 13'd5243;
   localparam logic [30:0] PclkDefault = 31'd48000000;
   localparam logic [31:0] ErrMax      = 32'h7fff_ffff;

   // csr register index
   localparam logic CsrPclkIdx = 1'b0;

   // queued request
   typedef struct packed {
      logic [BaudWidth-1:0] baud;
      logic                 zero;
   } item_type;

   // divider request and response
   typedef struct packed {
      logic                start;
      logic [DvdWidth-1:0] dividend;
      logic [DvsWidth-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DvdWidth-1:0] quot;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_Q,
      ST_Q_W,
      ST_T,
      ST_ACT,
      ST_ACT_W,
      ST_ERR,
      ST_ERR_W,
      ST_NEXT,
      ST_EMIT
   } back_state_type;

endpackage

/* design/ubds_front.sv */
module ubds_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [20:0]          req_baud_rate,
   output logic                 item_valid,
   output ubds_pkg::item_type   item,
   input  logic                 item_take
);

   ubds_pkg::item_type slot_ff [ubds_pkg::QueueDepth];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       push, pop;

   // queue flags
   assign req_ready  = (count_ff != 3'(ubds_pkg::QueueDepth));
   assign item_valid = (count_ff != 3'd0);
   assign item       = slot_ff[rd_ptr_ff];
   assign push       = req_valid & req_ready;
   assign pop        = item_valid & item_take;

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + {2'b0, push} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // classify and store the transaction
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff].baud <= req_baud_rate;
         slot_ff[wr_ptr_ff].zero <= (req_baud_rate == 21'd0);
      end
   end

endmodule

/* design/ubds_div.sv */
module ubds_div (
   input  logic                  clock,
   input  logic                  reset,
   input  ubds_pkg::div_req_type req,
   output ubds_pkg::div_rsp_type rsp
);

   logic [ubds_pkg::DvdWidth-1:0] dvd_ff, dvd_in;
   logic [ubds_pkg::DvsWidth-1:0] dvs_ff, dvs_in;
   logic [ubds_pkg::DvsWidth-1:0] rem_ff, rem_in;
   logic [5:0]                    cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [ubds_pkg::DvsWidth:0]   trial;
   logic [ubds_pkg::DvsWidth:0]   diff;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial   = {rem_ff, dvd_ff[ubds_pkg::DvdWidth-1]};
      diff    = trial - {1'b0, dvs_ff};
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         dvd_in  = req.dividend;
         dvs_in  = req.divisor;
         rem_in  = '0;
         cnt_in  = 6'(ubds_pkg::DvdWidth - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[ubds_pkg::DvsWidth]) begin
            rem_in = diff[ubds_pkg::DvsWidth-1:0];
            dvd_in = {dvd_ff[ubds_pkg::DvdWidth-2:0], 1'b1};
         end else begin
            rem_in = trial[ubds_pkg::DvsWidth-1:0];
            dvd_in = {dvd_ff[ubds_pkg::DvdWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = dvd_ff;

endmodule

/* design/ubds_back.sv */
module ubds_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [30:0]           pclk,
   input  logic                  item_valid,
   input  ubds_pkg::item_type    item,
   output logic                  item_take,
   output ubds_pkg::div_req_type div_req,
   input  ubds_pkg::div_rsp_type div_rsp,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_prescale_select,
   output logic [1:0]            rsp_base_divisor_select,
   output logic [7:0]            rsp_rate_register,
   output logic [31:0]           rsp_rate_error,
   output logic                  rsp_found
);

   ubds_pkg::back_state_type state_ff, state_in;

   logic [20:0] baud_ff, baud_in;
   logic [3:0]  cand_ff, cand_in;
   logic [8:0]  t_ff, t_in;
   logic [28:0] act_ff, act_in;
   logic        have_ff, have_in;
   logic [45:0] best_mag_ff, best_mag_in;
   logic        best_neg_ff, best_neg_in;
   logic [3:0]  best_cand_ff, best_cand_in;
   logic [7:0]  best_reg_ff, best_reg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  out_psel_ff, out_dsel_ff;
   logic [7:0]  out_reg_ff;
   logic [31:0] out_err_ff;
   logic        out_found_ff;
   logic        load;

   logic [31:0] num;
   logic [38:0] num_pct;
   logic [3:0]  shamt;
   logic [22:0] baud_x;
   logic [10:0] t_x;
   logic [33:0] den_baud;
   logic [33:0] den_t;
   logic [28:0] abs_diff;
   logic        neg;
   logic [45:0] err_dvd;
   logic [45:0] mag;
   logic [31:0] err_sat;
   logic [47:0] q_round;
   logic [27:0] t_prod;
   logic [8:0]  t_calc;
   logic        t_skip;

   // candidate scaling: base divisor 12 is 3 << 2, the rest are powers of two
   always_comb begin
      unique case (cand_ff[3:2])
         2'd0:    shamt = 4'd2;
         2'd1:    shamt = 4'd4;
         2'd2:    shamt = 4'd5;
         default: shamt = 4'd6;
      endcase
      unique case (cand_ff[1:0])
         2'd0:    shamt = shamt;
         2'd1:    shamt = shamt + 4'd1;
         2'd2:    shamt = shamt + 4'd3;
         default: shamt = shamt + 4'd5;
      endcase
      baud_x = (cand_ff[3:2] == 2'd0) ? {baud_ff, 1'b0} + {2'b0, baud_ff}
                                      : {2'b0, baud_ff};
      t_x    = (cand_ff[3:2] == 2'd0) ? {t_ff, 1'b0} + {2'b0, t_ff} : {2'b0, t_ff};
      den_baud = {11'b0, baud_x} << shamt;
      den_t    = {23'b0, t_x} << shamt;
      num      = (cand_ff[1:0] == 2'd0) ? {pclk, 1'b0} : {1'b0, pclk};
      num_pct  = {7'b0, num} * {32'b0, ubds_pkg::PctScale};
   end

   // rounded register value, divide by one hundred through a reciprocal
   always_comb begin
      q_round = div_rsp.quot + {41'b0, ubds_pkg::RoundHalf};
      t_prod  = {13'b0, q_round[14:0]} * {15'b0, ubds_pkg::PctRecip};
      t_calc  = t_prod[27:19];
      t_skip  = (q_round < {41'b0, ubds_pkg::PctScale})
             || (q_round >= {33'b0, ubds_pkg::RateLimit});
   end

   // error magnitude before the divide by the requested rate, and the saturated signed error of the best
   always_comb begin
      neg      = ({8'b0, baud_ff} > act_ff);
      abs_diff = neg ? {8'b0, baud_ff} - act_ff : act_ff - {8'b0, baud_ff};
      err_dvd  = {17'b0, abs_diff} * {29'b0, ubds_pkg::ErrScale};
      mag      = div_rsp.quot[45:0];
      err_sat  = best_neg_ff ? 32'(-best_mag_ff[31:0])
               : (best_mag_ff > {14'b0, ubds_pkg::ErrMax}) ? ubds_pkg::ErrMax
               : best_mag_ff[31:0];
   end

   // sequencer over the sixteen candidates
   always_comb begin
      state_in     = state_ff;
      baud_in      = baud_ff;
      cand_in      = cand_ff;
      t_in         = t_ff;
      act_in       = act_ff;
      have_in      = have_ff;
      best_mag_in  = best_mag_ff;
      best_neg_in  = best_neg_ff;
      best_cand_in = best_cand_ff;
      best_reg_in  = best_reg_ff;
      item_take    = 1'b0;
      load         = 1'b0;
      div_req      = '0;
      unique case (state_ff)
         ubds_pkg::ST_IDLE: begin
            if (item_valid) begin
               item_take = 1'b1;
               baud_in   = item.baud;
               cand_in   = '0;
               have_in   = 1'b0;
               state_in  = item.zero ? ubds_pkg::ST_EMIT : ubds_pkg::ST_Q;
            end
         end
         ubds_pkg::ST_Q: begin
            div_req.start    = 1'b1;
            div_req.dividend = {9'b0, num_pct};
            div_req.divisor  = den_baud[31:0];
            state_in         = ubds_pkg::ST_Q_W;
         end
         ubds_pkg::ST_Q_W: begin
            if (div_rsp.done) state_in = ubds_pkg::ST_T;
         end
         ubds_pkg::ST_T: begin
            if (t_skip) begin
               state_in = ubds_pkg::ST_NEXT;
            end else begin
               t_in     = t_calc;
               state_in = ubds_pkg::ST_ACT;
            end
         end
         ubds_pkg::ST_ACT: begin
            div_req.start    = 1'b1;
            div_req.dividend = {16'b0, num};
            div_req.divisor  = den_t[31:0];
            state_in         = ubds_pkg::ST_ACT_W;
         end
         ubds_pkg::ST_ACT_W: begin
            if (div_rsp.done) begin
               act_in   = div_rsp.quot[28:0];
               state_in = ubds_pkg::ST_ERR;
            end
         end
         ubds_pkg::ST_ERR: begin
            div_req.start    = 1'b1;
            div_req.dividend = {2'b0, err_dvd};
            div_req.divisor  = {11'b0, baud_ff};
            state_in         = ubds_pkg::ST_ERR_W;
         end
         ubds_pkg::ST_ERR_W: begin
            if (div_rsp.done) begin
               if (!have_ff || mag < best_mag_ff) begin
                  have_in      = 1'b1;
                  best_mag_in  = mag;
                  best_neg_in  = neg;
                  best_cand_in = cand_ff;
                  best_reg_in  = 8'(t_ff - 9'd1);
               end
               state_in = ubds_pkg::ST_NEXT;
            end
         end
         ubds_pkg::ST_NEXT: begin
            cand_in  = cand_ff + 4'd1;
            state_in = (cand_ff == 4'hf) ? ubds_pkg::ST_EMIT : ubds_pkg::ST_Q;
         end
         ubds_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load     = 1'b1;
               state_in = ubds_pkg::ST_IDLE;
            end
         end
         default: state_in = ubds_pkg::ST_IDLE;
      endcase
      rsp_valid_in = load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ubds_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         have_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         have_ff      <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      baud_ff      <= baud_in;
      cand_ff      <= cand_in;
      t_ff         <= t_in;
      act_ff       <= act_in;
      best_mag_ff  <= best_mag_in;
      best_neg_ff  <= best_neg_in;
      best_cand_ff <= best_cand_in;
      best_reg_ff  <= best_reg_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (load) begin
         out_found_ff <= have_ff;
         out_psel_ff  <= have_ff ? best_cand_ff[1:0] : 2'd0;
         out_dsel_ff  <= have_ff ? best_cand_ff[3:2] : 2'd0;
         out_reg_ff   <= have_ff ? best_reg_ff : 8'd0;
         out_err_ff   <= have_ff ? err_sat : 32'd0;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_prescale_select     = out_psel_ff;
   assign rsp_base_divisor_select = out_dsel_ff;
   assign rsp_rate_register       = out_reg_ff;
   assign rsp_rate_error          = out_err_ff;
   assign rsp_found               = out_found_ff;

endmodule

/* design/uart_baud_divisor_search.sv */
// channel   | handshake                  | payload
// req       | req_valid / req_ready      | req_baud_rate
// rsp       | rsp_valid / rsp_ready      | prescale, base divisor, register, error, found
// csr       | csr_psel/penable/pwrite    | csr_paddr, csr_pwdata, csr_prdata
//
// a four-entry queue takes requests every cycle while the search runs, as long as it is not full
// the search shares one radix-2 divider, one or three divides for each of
// sixteen candidates; a zero rate skips the divider
// synchronous active-high reset clears queue, sequencer and csr to 48 MHz
// the result register holds while rsp_valid is high and rsp_ready is low; the search then waits
module uart_baud_divisor_search (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [20:0] req_baud_rate,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_prescale_select,
   output logic [1:0]  rsp_base_divisor_select,
   output logic [7:0]  rsp_rate_register,
   output logic signed [31:0] rsp_rate_error,
   output logic        rsp_found,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [30:0]           pclk_ff, pclk_in;
   logic                  csr_wr;
   logic                  item_valid, item_take;
   ubds_pkg::item_type    item;
   ubds_pkg::div_req_type div_req;
   ubds_pkg::div_rsp_type div_rsp;
   logic [31:0]           err_bits;

   // csr write and read
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   always_comb begin
      pclk_in = pclk_ff;
      if (csr_wr && csr_paddr[2] == ubds_pkg::CsrPclkIdx)
         pclk_in = csr_pwdata[30:0];
      csr_prdata = (csr_paddr[2] == ubds_pkg::CsrPclkIdx) ? {1'b0, pclk_ff} : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pclk_ff <= ubds_pkg::PclkDefault;
      end else begin
         pclk_ff <= pclk_in;
      end
   end

   ubds_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_baud_rate (req_baud_rate),
      .item_valid    (item_valid),
      .item          (item),
      .item_take     (item_take)
   );

   ubds_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   ubds_back u_back (
      .clock                   (clock),
      .reset                   (reset),
      .pclk                    (pclk_ff),
      .item_valid              (item_valid),
      .item                    (item),
      .item_take               (item_take),
      .div_req                 (div_req),
      .div_rsp                 (div_rsp),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_prescale_select     (rsp_prescale_select),
      .rsp_base_divisor_select (rsp_base_divisor_select),
      .rsp_rate_register       (rsp_rate_register),
      .rsp_rate_error          (err_bits),
      .rsp_found               (rsp_found)
   );

   assign rsp_rate_error = err_bits;

`ifndef SYNTHESIS
   // nothing fitted: every field is zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_rate_error == 0 && rsp_rate_register == 8'd0
         && rsp_prescale_select == 2'd0 && rsp_base_divisor_select == 2'd0)
      else $error("empty result carries data");

   // a low achieved rate never errs below minus one hundred percent
   a_neg_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rate_error < 0 |-> rsp_rate_error >= -32'sd100000)
      else $error("negative error out of range");

   // a divide start is never followed at once by another start
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> !div_req.start)
      else $error("divider restarted");

   // clock register follows a write to its address
   a_csr_wr: assert property (@(posedge clock) disable iff (reset)
      csr_wr && csr_paddr == 3'd0 |=> pclk_ff == $past(csr_pwdata[30:0]))
      else $error("clock register not written");
`endif

endmodule

/* dv/uart_baud_divisor_search_tb.sv */
module uart_baud_divisor_search_tb;

   localparam logic [2:0] PclkAddr    = {1'b0, ubds_pkg::CsrPclkIdx, 2'b00};
   localparam int         CycleLimit  = 20_000_000;
   localparam int         LongHold    = 20_000;
   localparam int         PhaseItems  = 140;

   // one search outcome
   typedef struct {
      logic [1:0]         prescale;
      logic [1:0]         base_div;
      logic [7:0]         rate_reg;
      logic signed [31:0] rate_err;
      logic               found;
   } search_result_type;

   // expected search outcomes and their checking
   class divisor_scoreboard;
      search_result_type pending[$];
      int                fails;

      function automatic search_result_type search_divisor(logic [20:0] baud,
                                                           logic [30:0] pclk);
         longint unsigned   base_tab[4];
         longint unsigned   pre_tab[4];
         longint unsigned   mul, den, q, t, rg, act, mag, best_mag;
         longint            err, best_err;
         bit                have;
         search_result_type r;
         base_tab = '{12, 16, 32, 64};
         pre_tab  = '{1, 2, 8, 32};
         have     = 0;
         best_mag = 0;
         best_err = 0;
         r        = '{2'd0, 2'd0, 8'd0, 32'sd0, 1'b0};
         if (baud != 0) begin
            // divisor outer, prescale inner; first strict minimum wins
            for (int di = 0; di < 4; di++) begin
               for (int pi = 0; pi < 4; pi++) begin
                  mul = (pi == 0) ? 2 : 1;
                  den = base_tab[di] * pre_tab[pi];
                  q   = (longint'(pclk) * 100 * mul) / (den * longint'(baud));
                  t   = (q + 50) / 100;
                  if (t == 0 || t - 1 > 255) continue;
                  rg  = t - 1;
                  act = (longint'(pclk) * mul) / (den * (rg + 1));
                  err = ((longint'(act) - longint'(baud)) * 100000) / longint'(baud);
                  mag = (err < 0) ? -err : err;
                  if (!have || mag < best_mag) begin
                     have       = 1;
                     best_mag   = mag;
                     best_err   = err;
                     r.prescale = pi[1:0];
                     r.base_div = di[1:0];
                     r.rate_reg = rg[7:0];
                  end
               end
            end
         end
         if (have) begin
            // saturate to 32 bits
            if (best_err > 64'sd2147483647) best_err = 64'sd2147483647;
            if (best_err < -64'sd2147483648) best_err = -64'sd2147483648;
            r.rate_err = best_err[31:0];
            r.found    = 1'b1;
         end
         return r;
      endfunction

      function void note_request(logic [20:0] baud, logic [30:0] pclk);
         pending.push_back(search_divisor(baud, pclk));
      endfunction

      function void check_result(search_result_type got);
         search_result_type exp_r;
         if (pending.size() == 0) begin
            $error("result with no request outstanding");
            fails++;
            return;
         end
         exp_r = pending.pop_front();
         if (got.prescale !== exp_r.prescale) begin
            $error("prescale_select: expected %0d got %0d", exp_r.prescale, got.prescale);
            fails++;
         end
         if (got.base_div !== exp_r.base_div) begin
            $error("base_divisor_select: expected %0d got %0d", exp_r.base_div,
                   got.base_div);
            fails++;
         end
         if (got.rate_reg !== exp_r.rate_reg) begin
            $error("rate_register: expected %0d got %0d", exp_r.rate_reg, got.rate_reg);
            fails++;
         end
         if (got.rate_err !== exp_r.rate_err) begin
            $error("rate_error: expected %0d got %0d", exp_r.rate_err, got.rate_err);
            fails++;
         end
         if (got.found !== exp_r.found) begin
            $error("found: expected %0d got %0d", exp_r.found, got.found);
            fails++;
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [20:0]        req_baud_rate = '0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [1:0]         rsp_prescale_select;
   logic [1:0]         rsp_base_divisor_select;
   logic [7:0]         rsp_rate_register;
   logic signed [31:0] rsp_rate_error;
   logic               rsp_found;
   logic               csr_psel = 0;
   logic               csr_penable = 0;
   logic               csr_pwrite = 0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   divisor_scoreboard  sb = new();
   logic [30:0]        pclk_model = ubds_pkg::PclkDefault;
   int                 cycles = 0;
   int                 results_seen = 0;
   bit                 burst_mode = 0;

   uart_baud_divisor_search dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // register write then readback
   task automatic write_pclk(logic [30:0] value);
      @(negedge clock);
      csr_psel   = 1;
      csr_pwrite = 1;
      csr_penable = 0;
      csr_paddr  = PclkAddr;
      csr_pwdata = {1'b0, value};
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      pclk_model = value;
      @(negedge clock);
      csr_pwrite  = 0;
      csr_penable = 0;
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[30:0] !== value) begin
         $error("pclk_frequency_hz readback: expected %0d got %0d", value,
                csr_prdata[30:0]);
         sb.fails++;
      end
      @(negedge clock);
      csr_psel    = 0;
      csr_penable = 0;
   endtask

   // offer one baud request and wait for acceptance; valid stays up for the next
   task automatic send_baud(logic [20:0] baud);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     = 1;
      req_baud_rate = baud;
      do @(posedge clock); while (!req_ready);
      sb.note_request(baud, pclk_model);
   endtask

   function automatic logic [20:0] pick_baud();
      logic [20:0] common_rates[8];
      common_rates = '{21'd300, 21'd1200, 21'd9600, 21'd19200, 21'd38400,
                       21'd57600, 21'd115200, 21'd921600};
      case ($urandom_range(0, 3))
         0: return common_rates[$urandom_range(0, 7)];
         1: return 21'($urandom_range(1, 4000));
         2: return 21'($urandom_range(4000, 300000));
         default: return 21'($urandom);
      endcase
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // result side: random stalls, one long hold-off
   initial begin
      search_result_type got;
      int stall;
      bit held;
      held = 0;
      forever begin
         stall = burst_mode ? 0 : $urandom_range(0, 17);
         if (!held && results_seen == 60) begin
            stall = LongHold;
            held  = 1;
         end
         @(negedge clock);
         rsp_ready = 0;
         repeat (stall) @(negedge clock);
         rsp_ready = 1;
         do @(posedge clock); while (!rsp_valid);
         got.prescale = rsp_prescale_select;
         got.base_div = rsp_base_divisor_select;
         got.rate_reg = rsp_rate_register;
         got.rate_err = rsp_rate_error;
         got.found    = rsp_found;
         sb.check_result(got);
         results_seen++;
      end
   end

   // stimulus
   initial begin
      logic [30:0] clock_settings[6];
      clock_settings = '{31'd2000000000, 31'd1, 31'd0, 31'h7fffffff, 31'd1843200,
                         31'd0};
      clock_settings[5] = 31'($urandom_range(1000, 200000000));
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed corners at the reset clock
      send_baud(21'd0);
      send_baud(21'd1);
      send_baud(21'd2);
      send_baud(21'h1fffff);
      send_baud(21'd9600);
      send_baud(21'd115200);
      send_baud(21'd300);
      send_baud(21'd1000000);
      send_baud(21'd187500);
      send_baud(21'd2000000);
      send_baud(21'h155555);
      send_baud(21'h0aaaaa);
      for (int i = 0; i < PhaseItems; i++) begin
         burst_mode = (i / 20) % 3 == 2;
         send_baud(pick_baud());
      end
      wait_drained();

      // further clock settings
      foreach (clock_settings[k]) begin
         write_pclk(clock_settings[k]);
         send_baud(21'd0);
         send_baud(21'd1);
         send_baud(21'h1fffff);
         for (int i = 0; i < PhaseItems - 20; i++) begin
            burst_mode = (i / 20) % 3 == 2;
            send_baud(pick_baud());
         end
         wait_drained();
      end
      burst_mode = 0;

      wait_drained();
      repeat (100) @(posedge clock);
      if (sb.fails == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
design/ubds_pkg.sv
design/ubds_front.sv
design/ubds_div.sv
design/ubds_back.sv
design/uart_baud_divisor_search.sv
dv/uart_baud_divisor_search_tb.sv
